// ===== rtl/bss_pkg.sv =====
// Shared types and constants of the backup supply supervisor.
package bss_pkg;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_MON   = 2'd1,
        PH_HOLD  = 2'd2,
        PH_PAUSE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CFG_START_LEVEL   = 3'd0,
        CFG_PRESENT_LEVEL = 3'd1,
        CFG_LOW_LEVEL     = 3'd2,
        CFG_LOSS_TIMEOUT  = 3'd3,
        CFG_RECOVER_COUNT = 3'd4,
        CFG_HOLD_SAMPLES  = 3'd5,
        CFG_PAUSE_SAMPLES = 3'd6
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [4:0] DRV_OFF    = 5'h00;
    localparam logic [4:0] DRV_ON     = 5'h01;
    localparam logic [4:0] DRV_CHARGE = 5'h11;
    localparam logic [4:0] DRV_LOW    = 5'h13;
    localparam logic [4:0] DRV_BATT   = 5'h1B;

    localparam logic [7:0]  RST_START_LEVEL   = 8'd33;
    localparam logic [7:0]  RST_PRESENT_LEVEL = 8'd30;
    localparam logic [7:0]  RST_LOW_LEVEL     = 8'd27;
    localparam logic [15:0] RST_LOSS_TIMEOUT  = 16'd45000;
    localparam logic [9:0]  RST_RECOVER_COUNT = 10'd1000;
    localparam logic [23:0] RST_HOLD_SAMPLES  = 24'd172800;
    localparam logic [23:0] RST_PAUSE_SAMPLES = 24'd23040;

    typedef struct packed {
        logic [7:0]  start_level;
        logic [7:0]  present_level;
        logic [7:0]  low_level;
        logic [15:0] loss_timeout;
        logic [9:0]  recover_count;
        logic [23:0] hold_samples;
        logic [23:0] pause_samples;
    } bss_cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] loss_cnt;
        logic [9:0]  recovery_cnt;
        logic [23:0] delay_cnt;
        logic [4:0]  drive;
    } bss_state_t;

    typedef struct packed {
        logic [4:0] port_drive;
        logic [1:0] phase_now;
    } bss_result_t;

endpackage

// ===== rtl/backup_supply_supervisor_core.sv =====
// Top level of the backup supply supervisor: input stage, state, output skid buffer.
// Throughput: one word per cycle unless output and skid entry are both full; an accepted
// word moves from the input register into the output register or skid entry. The phase
// and counter update is a single pass between the input register and the output register.
// The output register plus one skid entry keep the input open while a result waits.
// Reset (rst_n low, asynchronous) clears the supervisor state and valid flags, loads default register values.
module backup_supply_supervisor_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [2:0]                           cfg_index,
    input  logic [bss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [4:0]                           port_drive,
    output logic [1:0]                           phase_now
);
    import bss_pkg::*;

    bss_cfg_t    cfg_reg;
    bss_state_t  state_reg;
    bss_state_t  state_next;
    logic        in_valid_reg;
    logic [7:0]  sample_reg;
    logic        out_valid_reg;
    bss_result_t out_data_reg;
    logic        skid_valid_reg;
    bss_result_t skid_data_reg;
    bss_result_t push_data;
    logic        full;
    logic        advance;
    logic        accept;
    logic        pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level   <= RST_START_LEVEL;
            cfg_reg.present_level <= RST_PRESENT_LEVEL;
            cfg_reg.low_level     <= RST_LOW_LEVEL;
            cfg_reg.loss_timeout  <= RST_LOSS_TIMEOUT;
            cfg_reg.recover_count <= RST_RECOVER_COUNT;
            cfg_reg.hold_samples  <= RST_HOLD_SAMPLES;
            cfg_reg.pause_samples <= RST_PAUSE_SAMPLES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_LEVEL:   cfg_reg.start_level   <= cfg_data[7:0];
                CFG_PRESENT_LEVEL: cfg_reg.present_level <= cfg_data[7:0];
                CFG_LOW_LEVEL:     cfg_reg.low_level     <= cfg_data[7:0];
                CFG_LOSS_TIMEOUT:  cfg_reg.loss_timeout  <= cfg_data[15:0];
                CFG_RECOVER_COUNT: cfg_reg.recover_count <= cfg_data[9:0];
                CFG_HOLD_SAMPLES:  cfg_reg.hold_samples  <= cfg_data[23:0];
                CFG_PAUSE_SAMPLES: cfg_reg.pause_samples <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full     = out_valid_reg && skid_valid_reg;
    assign advance  = in_valid_reg && !full;
    assign in_stall = in_valid_reg && full;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
        end
    end

    bss_step u_step (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .sample (sample_reg),
        .nxt    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_WAIT;
            state_reg.loss_cnt     <= 16'd0;
            state_reg.recovery_cnt <= 10'd0;
            state_reg.delay_cnt    <= 24'd0;
            state_reg.drive        <= DRV_OFF;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign push_data.port_drive = state_next.drive;
    assign push_data.phase_now  = state_next.phase;

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || advance;
            skid_valid_reg <= skid_valid_reg && advance;
        end
        else if (advance)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (advance)
                begin
                    skid_data_reg <= push_data;
                end
            end
            else if (advance)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (advance)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign port_drive = out_data_reg.port_drive;
    assign phase_now  = out_data_reg.phase_now;

    // The skid entry is only ever occupied behind a valid output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // The skid entry fills only when the output word was stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled without an output stall");

    // Battery hold always drives the battery pattern; wait and pause keep outputs off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_HOLD && state_reg.drive == DRV_BATT)
        || (state_reg.phase == PH_MON)
        || ((state_reg.phase == PH_WAIT || state_reg.phase == PH_PAUSE)
            && state_reg.drive == DRV_OFF))
        else $error("drive pattern inconsistent with phase");

endmodule

// ===== rtl/bss_step.sv =====
// Per-sample phase and counter update of the supervisor.
module bss_step (
    input  bss_pkg::bss_cfg_t   cfg,
    input  bss_pkg::bss_state_t cur,
    input  logic [7:0]          sample,
    output bss_pkg::bss_state_t nxt
);
    import bss_pkg::*;

    logic        present;
    logic        low;
    logic        arm;
    logic [15:0] mon_loss;
    logic        delay_done;

    assign present    = sample > cfg.present_level;
    assign low        = sample < cfg.low_level;
    assign arm        = sample >= cfg.start_level;
    assign delay_done = (cur.delay_cnt[23:1] == 23'd0);

    always_comb
    begin
        if (present)
        begin
            mon_loss = cfg.loss_timeout;
        end
        else if (cur.loss_cnt != 16'd0)
        begin
            mon_loss = cur.loss_cnt - 16'd1;
        end
        else
        begin
            mon_loss = cur.loss_cnt;
        end
    end

    // Next phase.
    always_comb
    begin
        nxt.phase = cur.phase;
        case (cur.phase)
            PH_WAIT:
            begin
                if (arm)
                begin
                    nxt.phase = (cfg.loss_timeout == 16'd0) ? PH_HOLD : PH_MON;
                end
            end
            PH_MON:
            begin
                if (mon_loss == 16'd0)
                begin
                    nxt.phase = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                if (delay_done)
                begin
                    nxt.phase = PH_PAUSE;
                end
            end
            PH_PAUSE:
            begin
                if (delay_done)
                begin
                    nxt.phase = PH_WAIT;
                end
            end
            default:
            begin
                nxt.phase = PH_WAIT;
            end
        endcase
    end

    // Counters and drive pattern.
    always_comb
    begin
        nxt.loss_cnt     = cur.loss_cnt;
        nxt.recovery_cnt = cur.recovery_cnt;
        nxt.delay_cnt    = cur.delay_cnt;
        nxt.drive        = cur.drive;
        case (cur.phase)
            PH_WAIT:
            begin
                if (arm)
                begin
                    nxt.loss_cnt = cfg.loss_timeout;
                    if (cfg.loss_timeout == 16'd0)
                    begin
                        nxt.drive     = DRV_BATT;
                        nxt.delay_cnt = cfg.hold_samples;
                    end
                    else
                    begin
                        nxt.drive = DRV_ON;
                    end
                end
            end
            PH_MON:
            begin
                nxt.loss_cnt = mon_loss;
                if (present)
                begin
                    if (cur.recovery_cnt == 10'd0)
                    begin
                        nxt.drive = DRV_CHARGE;
                    end
                    else
                    begin
                        nxt.recovery_cnt = cur.recovery_cnt - 10'd1;
                    end
                end
                // A low sample overrides whatever the present test did.
                if (low)
                begin
                    nxt.drive        = DRV_LOW;
                    nxt.recovery_cnt = cfg.recover_count;
                end
                if (mon_loss == 16'd0)
                begin
                    nxt.drive     = DRV_BATT;
                    nxt.delay_cnt = cfg.hold_samples;
                end
            end
            PH_HOLD:
            begin
                if (delay_done)
                begin
                    nxt.drive     = DRV_OFF;
                    nxt.delay_cnt = cfg.pause_samples;
                end
                else
                begin
                    nxt.delay_cnt = cur.delay_cnt - 24'd1;
                end
            end
            PH_PAUSE:
            begin
                if (delay_done)
                begin
                    nxt.drive     = DRV_OFF;
                    nxt.delay_cnt = 24'd0;
                end
                else
                begin
                    nxt.delay_cnt = cur.delay_cnt - 24'd1;
                end
            end
            default:
            begin
                nxt.drive = DRV_OFF;
            end
        endcase
    end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the backup supply supervisor core: directed table, then random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int           LIMIT_CYCLES    = 1000000;
    localparam int           RAND_PHASES     = 10;
    localparam int           ITEMS_PER_PHASE = 110;
    localparam int           BACKLOG_PHASE   = 2;
    localparam int           EXTREME_PHASE   = 4;
    localparam int           DRAIN_PHASE     = 5;
    localparam int           TOP_LEVEL_PHASE = 7;
    localparam int           ZERO_PHASE      = 8;
    localparam int           BACKLOG_CYCLES  = 300;
    localparam int           TAIL_CYCLES     = 8;
    localparam logic [2:0]   CFG_UNUSED_IDX  = 3'd7;

    typedef enum int {
        MODE_GOOD,
        MODE_SAG,
        MODE_LOW,
        MODE_ANY,
        MODE_ARM
    } sample_mode_t;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_CHECKED,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [23:0] data;
        logic [7:0]  smp;
        logic [4:0]  drv;
        phase_t      ph;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [4:0]            port_drive;
    logic [1:0]            phase_now;

    // Shadow of the block: registers and supervisor state.
    bss_cfg_t    shadow_cfg;
    phase_t      sup_phase;
    logic [15:0] loss_left;
    logic [9:0]  recov_left;
    logic [23:0] delay_left;
    logic [4:0]  drive_pat;

    bss_result_t due_outputs[$];
    stim_row_t   stim_rows[$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          offering = 1'b0;
    bit          writing = 1'b0;
    bit          backlog_req = 1'b0;
    bit          backlog_done = 1'b0;

    backup_supply_supervisor_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .port_drive (port_drive),
        .phase_now  (phase_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void apply_reg(input logic [2:0] idx, input logic [23:0] v);
        case (idx)
            CFG_START_LEVEL:   shadow_cfg.start_level   = v[7:0];
            CFG_PRESENT_LEVEL: shadow_cfg.present_level = v[7:0];
            CFG_LOW_LEVEL:     shadow_cfg.low_level     = v[7:0];
            CFG_LOSS_TIMEOUT:  shadow_cfg.loss_timeout  = v[15:0];
            CFG_RECOVER_COUNT: shadow_cfg.recover_count = v[9:0];
            CFG_HOLD_SAMPLES:  shadow_cfg.hold_samples  = v;
            CFG_PAUSE_SAMPLES: shadow_cfg.pause_samples = v;
            default: ;
        endcase
    endfunction

    function automatic void enter_battery();
        drive_pat  = DRV_BATT;
        delay_left = shadow_cfg.hold_samples;
        sup_phase  = PH_HOLD;
    endfunction

    function automatic bss_result_t next_supply_outputs(input logic [7:0] s);
        bss_result_t r;
        case (sup_phase)
            PH_WAIT:
            begin
                if (s >= shadow_cfg.start_level)
                begin
                    drive_pat = DRV_ON;
                    loss_left = shadow_cfg.loss_timeout;
                    sup_phase = PH_MON;
                    if (loss_left == 16'd0)
                        enter_battery();
                end
            end
            PH_MON:
            begin
                if (s > shadow_cfg.present_level)
                begin
                    loss_left = shadow_cfg.loss_timeout;
                    if (recov_left == 10'd0)
                        drive_pat = DRV_CHARGE;
                    else
                        recov_left = recov_left - 10'd1;
                end
                else if (loss_left != 16'd0)
                begin
                    loss_left = loss_left - 16'd1;
                end
                // A low sample overrides whatever the present branch drove.
                if (s < shadow_cfg.low_level)
                begin
                    drive_pat  = DRV_LOW;
                    recov_left = shadow_cfg.recover_count;
                end
                if (loss_left == 16'd0)
                    enter_battery();
            end
            PH_HOLD:
            begin
                if (delay_left <= 24'd1)
                begin
                    drive_pat  = DRV_OFF;
                    delay_left = shadow_cfg.pause_samples;
                    sup_phase  = PH_PAUSE;
                end
                else
                begin
                    delay_left = delay_left - 24'd1;
                end
            end
            default:
            begin
                if (delay_left <= 24'd1)
                begin
                    delay_left = 24'd0;
                    drive_pat  = DRV_OFF;
                    sup_phase  = PH_WAIT;
                end
                else
                begin
                    delay_left = delay_left - 24'd1;
                end
            end
        endcase
        r.port_drive = drive_pat;
        r.phase_now  = sup_phase;
        return r;
    endfunction

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(25, 4);
    endfunction

    function automatic logic [7:0] pick_between(input int lo, input int hi);
        if (lo > hi)
            return 8'($urandom_range(255, 0));
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] pick_sample(input sample_mode_t m);
        case (m)
            MODE_GOOD: return pick_between(int'(shadow_cfg.present_level) + 1, 255);
            MODE_SAG:  return pick_between(int'(shadow_cfg.low_level),
                                           int'(shadow_cfg.present_level));
            MODE_LOW:  return pick_between(0, int'(shadow_cfg.low_level) - 1);
            MODE_ARM:  return pick_between(int'(shadow_cfg.start_level), 255);
            default:   return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // Fills the bits above a register's width with junk; the block must drop them.
    function automatic logic [23:0] with_junk(input logic [23:0] v, input int width);
        logic [23:0] mask;
        logic [23:0] junk;
        mask = (24'h1 << width) - 24'h1;
        junk = 24'($urandom);
        if (width >= 24)
            return v;
        return (junk & ~mask) | (v & mask);
    endfunction

    function automatic void add_plain(input logic [7:0] s);
        stim_rows.push_back('{ROW_SAMPLE, 3'd0, 24'd0, s, DRV_OFF, PH_WAIT});
    endfunction

    function automatic void add_checked(input logic [7:0] s, input logic [4:0] drv,
                                        input phase_t ph);
        stim_rows.push_back('{ROW_CHECKED, 3'd0, 24'd0, s, drv, ph});
    endfunction

    function automatic void add_write(input logic [2:0] idx, input logic [23:0] data);
        stim_rows.push_back('{ROW_WRITE, idx, data, 8'd0, DRV_OFF, PH_WAIT});
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        writing = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, value);
    endtask

    task automatic drain_outputs();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (due_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic [7:0] s, input int gap, input bit typed,
                               input bss_result_t typed_res);
        bss_result_t res;
        if (writing)
        begin
            cfg_valid <= 1'b0;
            writing = 1'b0;
        end
        if (gap > 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        res = next_supply_outputs(s);
        due_outputs.push_back(typed ? typed_res : res);
    endtask

    always @(posedge clk)
    begin
        bss_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_outputs.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing due: drive %h phase %0d",
                                          port_drive, phase_now));
            end
            else
            begin
                want = due_outputs.pop_front();
                if (port_drive !== want.port_drive)
                    report_mismatch($sformatf("port_drive %h, want %h",
                                              port_drive, want.port_drive));
                if (phase_now !== want.phase_now)
                    report_mismatch($sformatf("phase_now %0d, want %0d",
                                              phase_now, want.phase_now));
            end
        end
    end

    initial
    begin : rx_pacer
        int roll;
        int len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            roll = $urandom_range(99, 0);
            if (backlog_req && !backlog_done)
            begin
                // Long hold-off so the block fills and pushes back on the sender.
                backlog_done = 1'b1;
                out_stall <= 1'b1;
                len = BACKLOG_CYCLES;
            end
            else if (roll < 50)
            begin
                out_stall <= 1'b0;
                len = $urandom_range(8, 1);
            end
            else if (roll < 85)
            begin
                out_stall <= 1'b1;
                len = $urandom_range(3, 1);
            end
            else if (roll < 93)
            begin
                out_stall <= 1'b1;
                len = $urandom_range(25, 4);
            end
            else
            begin
                out_stall <= 1'b0;
                len = $urandom_range(150, 40);
            end
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin : stim
        bss_result_t  typed_res;
        bit           calm;
        bit           drained_mid;
        int           counted;
        int           burst_left;
        int           roll;
        sample_mode_t mode;
        logic [7:0]   s;
        logic [7:0]   lv_start;
        logic [7:0]   lv_present;
        logic [7:0]   lv_low;
        logic [15:0]  t_loss;
        logic [9:0]   t_rec;
        logic [23:0]  t_hold;
        logic [23:0]  t_pause;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 3'd0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = 8'd0;
        shadow_cfg = '{RST_START_LEVEL, RST_PRESENT_LEVEL, RST_LOW_LEVEL, RST_LOSS_TIMEOUT,
                       RST_RECOVER_COUNT, RST_HOLD_SAMPLES, RST_PAUSE_SAMPLES};
        sup_phase  = PH_WAIT;
        loss_left  = 16'd0;
        recov_left = 10'd0;
        delay_left = 24'd0;
        drive_pat  = DRV_OFF;
        drained_mid = 1'b0;
        burst_left = 0;
        mode = MODE_ANY;

        // Reset defaults: arming threshold, charge, then a low sample.
        add_checked(8'd0,   DRV_OFF,    PH_WAIT);
        add_checked(8'd32,  DRV_OFF,    PH_WAIT);
        add_checked(8'd33,  DRV_ON,     PH_MON);
        add_checked(8'd255, DRV_CHARGE, PH_MON);
        add_checked(8'd0,   DRV_LOW,    PH_MON);
        add_plain(8'd31);
        add_plain(8'd30);
        // Short loss timeout, junk above the level width, minimal hold, zero pause.
        add_write(CFG_LOSS_TIMEOUT,  24'h000002);
        add_write(CFG_PRESENT_LEVEL, 24'hABCD64);
        add_write(CFG_LOW_LEVEL,     24'h000000);
        add_write(CFG_HOLD_SAMPLES,  24'h000001);
        add_write(CFG_PAUSE_SAMPLES, 24'h000000);
        add_plain(8'd200);
        add_plain(8'd100);
        add_checked(8'd99,  DRV_BATT, PH_HOLD);
        add_checked(8'd255, DRV_OFF,  PH_PAUSE);
        add_checked(8'd0,   DRV_OFF,  PH_WAIT);
        // Zero loss timeout sends the arming sample straight to battery; zero hold.
        add_write(CFG_LOSS_TIMEOUT,  24'h000000);
        add_write(CFG_START_LEVEL,   24'h0000FF);
        add_write(CFG_HOLD_SAMPLES,  24'h000000);
        add_write(CFG_PAUSE_SAMPLES, 24'h000002);
        add_write(CFG_UNUSED_IDX,    24'hFFFFFF);
        add_checked(8'd254, DRV_OFF,  PH_WAIT);
        add_checked(8'd255, DRV_BATT, PH_HOLD);
        add_checked(8'd7,   DRV_OFF,  PH_PAUSE);
        add_checked(8'd8,   DRV_OFF,  PH_PAUSE);
        add_checked(8'd9,   DRV_OFF,  PH_WAIT);
        // Overlapping levels: every sample from 1 to 254 is both present and low.
        add_write(CFG_START_LEVEL,   24'h000000);
        add_write(CFG_PRESENT_LEVEL, 24'h000000);
        add_write(CFG_LOW_LEVEL,     24'h0000FF);
        add_write(CFG_LOSS_TIMEOUT,  24'h000003);
        add_write(CFG_RECOVER_COUNT, 24'hFFFC00);
        add_write(CFG_HOLD_SAMPLES,  24'h000002);
        add_write(CFG_PAUSE_SAMPLES, 24'h000001);
        add_checked(8'd0,   DRV_ON,     PH_MON);
        add_plain(8'd128);
        add_plain(8'd128);
        add_checked(8'd255, DRV_CHARGE, PH_MON);
        add_plain(8'd0);
        add_plain(8'd0);
        add_checked(8'd0,   DRV_BATT,   PH_HOLD);
        add_plain(8'd0);
        add_plain(8'd0);
        add_plain(8'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_WRITE)
            begin
                drain_outputs();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end
            else
            begin
                typed_res.port_drive = stim_rows[i].drv;
                typed_res.phase_now  = stim_rows[i].ph;
                send_sample(stim_rows[i].smp, next_gap(), stim_rows[i].kind == ROW_CHECKED,
                            typed_res);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // Finish any battery episode under the old lengths so the maximum pause
            // length is never loaded.
            if (p == EXTREME_PHASE)
            begin
                while (sup_phase == PH_HOLD || sup_phase == PH_PAUSE)
                    send_sample(8'd0, next_gap(), 1'b0, typed_res);
            end
            drain_outputs();
            if (p == EXTREME_PHASE)
            begin
                lv_start   = 8'd0;
                lv_present = 8'd0;
                lv_low     = 8'd0;
                t_loss     = 16'hFFFF;
                t_rec      = 10'h3FF;
                t_hold     = 24'hFFFFFF;
                t_pause    = 24'hFFFFFF;
            end
            else if (p == TOP_LEVEL_PHASE)
            begin
                lv_start   = 8'd255;
                lv_present = 8'd255;
                lv_low     = 8'd255;
                t_loss     = 16'd1;
                t_rec      = 10'd0;
                t_hold     = 24'd1;
                t_pause    = 24'd1;
            end
            else
            begin
                lv_present = 8'($urandom_range(200, 40));
                lv_low = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0))
                                                     : 8'($urandom_range(lv_present, 10));
                lv_start = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0))
                                                       : 8'($urandom_range(255, lv_present));
                t_loss  = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(24, 1));
                t_rec   = 10'($urandom_range(12, 0));
                t_hold  = ($urandom_range(9, 0) == 0) ? 24'd0 : 24'($urandom_range(30, 1));
                t_pause = ($urandom_range(9, 0) == 0) ? 24'd0 : 24'($urandom_range(30, 1));
                if (p == ZERO_PHASE)
                begin
                    t_loss  = 16'd0;
                    t_hold  = 24'd0;
                    t_pause = 24'd0;
                end
            end
            write_reg(CFG_START_LEVEL,   with_junk(24'(lv_start), 8));
            write_reg(CFG_PRESENT_LEVEL, with_junk(24'(lv_present), 8));
            write_reg(CFG_LOW_LEVEL,     with_junk(24'(lv_low), 8));
            write_reg(CFG_LOSS_TIMEOUT,  with_junk(24'(t_loss), 16));
            write_reg(CFG_RECOVER_COUNT, with_junk(24'(t_rec), 10));
            write_reg(CFG_HOLD_SAMPLES,  t_hold);
            write_reg(CFG_PAUSE_SAMPLES, t_pause);
            if ($urandom_range(3, 0) == 0)
                write_reg(CFG_UNUSED_IDX, 24'($urandom));
            if (p == BACKLOG_PHASE)
                backlog_req = 1'b1;
            calm = ($urandom_range(3, 0) == 0);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                if (p == DRAIN_PHASE && counted == ITEMS_PER_PHASE / 2 && !drained_mid)
                begin
                    drained_mid = 1'b1;
                    drain_outputs();
                end
                if (burst_left == 0)
                begin
                    roll = $urandom_range(99, 0);
                    if (roll < 40)
                        mode = MODE_GOOD;
                    else if (roll < 65)
                        mode = MODE_SAG;
                    else if (roll < 80)
                        mode = MODE_LOW;
                    else if (roll < 90)
                        mode = MODE_ANY;
                    else
                        mode = MODE_ARM;
                    burst_left = $urandom_range(30, 1);
                end
                burst_left--;
                // The extreme phase keeps every sample present so no long hold is entered.
                if (p == EXTREME_PHASE)
                    s = 8'($urandom_range(255, 1));
                else
                    s = pick_sample(mode);
                send_sample(s, calm ? 0 : next_gap(), 1'b0, typed_res);
                counted++;
            end
        end

        drain_outputs();
        if (writing)
        begin
            cfg_valid <= 1'b0;
            writing = 1'b0;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_outputs.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", due_outputs.size()));
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bss_pkg.sv
rtl/bss_step.sv
rtl/backup_supply_supervisor_core.sv
bench/tb.sv
